@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the read-ahead window cache checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RAWC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RAWC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rawc_pkg.sv @@
// ----------------------------------------------------------------------------
// rawc_pkg
// Types, widths and codes shared by the read-ahead window cache modules.
// ----------------------------------------------------------------------------
package rawc_pkg;

	localparam int ADDR_W    = 40;
	localparam int LEN_W     = 32;
	localparam int WIN_SHIFT = 16;
	localparam int WIN_COUNT = 4;
	localparam int WIN_IDX_W = $clog2(WIN_COUNT);
	localparam int BASE_W    = ADDR_W - WIN_SHIFT;
	localparam int FILL_W    = WIN_SHIFT + 1;
	localparam int RANK_W    = WIN_IDX_W;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [BASE_W-1:0]    base_t;
	typedef logic [FILL_W-1:0]    fill_t;
	typedef logic [WIN_SHIFT-1:0] off_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [WIN_IDX_W-1:0] win_idx_t;

	// A full window, in bytes.
	localparam fill_t WIN_FULL = fill_t'(2 ** WIN_SHIFT);

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_DIRECT = 2'd1,
		ACT_HIT    = 2'd2,
		ACT_FILL   = 2'd3
	} action_t;

	typedef enum logic {
		REG_STORE_SIZE = 1'b0,
		REG_READ_AHEAD = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SINGLE,
		ST_SEG
	} state_t;

	// Search result that ripples from cell to cell.
	typedef struct packed {
		logic     hit;
		win_idx_t hit_idx;
		fill_t    hit_fill;
		rank_t    hit_rank;
		logic     free;
		win_idx_t free_idx;
		rank_t    free_rank;
		win_idx_t lru_idx;
		rank_t    lru_rank;
	} chain_t;

	// Address being looked up.
	typedef struct packed {
		base_t base;
		off_t  off;
	} probe_t;

	// Update broadcast to every cell when a segment is issued.
	typedef struct packed {
		logic     en;
		logic     load;
		win_idx_t win;
		base_t    base;
		fill_t    fill;
		rank_t    rank;
	} upd_t;

endpackage

@@ hw/rtl/rawc_cell.sv @@
// ----------------------------------------------------------------------------
// rawc_cell
// One window slot: tag, fill count and recency rank, plus its link of the
// lookup and replacement search chain.
// ----------------------------------------------------------------------------
module rawc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rawc_pkg::win_idx_t idx,
	input  logic              inv,
	input  rawc_pkg::probe_t  probe,
	input  rawc_pkg::upd_t    upd,
	input  rawc_pkg::chain_t  chain_in,
	output rawc_pkg::chain_t  chain_out
);
	import rawc_pkg::*;

	logic  valid_q;
	base_t base_q;
	fill_t fill_q;
	rank_t rank_q;
	logic  match;

	assign match = valid_q && (base_q == probe.base) && ({1'b0, probe.off} < fill_q);

	// Lowest matching and lowest empty slot win; the oldest rank wins on strict greater.
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.hit && match) begin
			chain_out.hit      = 1'b1;
			chain_out.hit_idx  = idx;
			chain_out.hit_fill = fill_q;
			chain_out.hit_rank = rank_q;
		end
		if (!chain_in.free && !valid_q) begin
			chain_out.free      = 1'b1;
			chain_out.free_idx  = idx;
			chain_out.free_rank = rank_q;
		end
		if (rank_q > chain_in.lru_rank) begin
			chain_out.lru_idx  = idx;
			chain_out.lru_rank = rank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			base_q  <= '0;
			fill_q  <= '0;
			rank_q  <= rank_t'(idx);
		end else begin
			if (inv) begin
				valid_q <= 1'b0;
			end else if (upd.en && upd.load && (upd.win == idx)) begin
				valid_q <= 1'b1;
				base_q  <= upd.base;
				fill_q  <= upd.fill;
			end
			if (upd.en) begin
				if (upd.win == idx) begin
					rank_q <= '0;
				end else if (rank_q < upd.rank) begin
					rank_q <= rank_q + rank_t'(1);
				end
			end
		end
	end

endmodule

@@ hw/rtl/read_ahead_window_cache_core.sv @@
// ----------------------------------------------------------------------------
// read_ahead_window_cache_core
// Fully associative read-ahead cache of aligned windows with true LRU ranks.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in      | in_valid in_ready position length uncached| in
//  out     | out_valid out_ready action window_index   | out
//          | fetch_address fill_bytes window_offset    |
//          | segment_bytes last                        |
//
// A request is taken in ST_IDLE, has its length clipped and is classified in
// ST_PREP, then gives its results: one for an empty or direct read, one or
// two for a cached read. No new request is taken before its last result is
// loaded. Each segment updates the LRU ranks before the next is looked up.
// Reset clears every window at once; there is no clearing pass.
// A stalled output holds in its register; the block only waits when a new
// result is ready and the previous one has not been taken.
// ----------------------------------------------------------------------------
module read_ahead_window_cache_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [39:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rawc_pkg::addr_t       position,
	input  rawc_pkg::len_t        length,
	input  logic                  uncached,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            action,
	output logic [1:0]            window_index,
	output rawc_pkg::addr_t       fetch_address,
	output rawc_pkg::fill_t       fill_bytes,
	output rawc_pkg::off_t        window_offset,
	output rawc_pkg::len_t        segment_bytes,
	output logic                  last
);
	import rawc_pkg::*;

	state_t state_q, state_d;

	addr_t store_size_q;
	logic  read_ahead_q;
	logic  inv;

	// Request registers. pos_q advances to the next window between segments.
	addr_t pos_q;
	len_t  len_q;
	logic  unc_q;
	len_t  req_q;
	logic  empty_q;
	logic  first_q;

	// Output register.
	logic     out_valid_q;
	action_t  out_action_q;
	win_idx_t out_win_q;
	addr_t    out_fetch_q;
	fill_t    out_fill_q;
	off_t     out_off_q;
	len_t     out_seg_q;
	logic     out_last_q;
	logic     out_free;

	// Classification of the request.
	logic [ADDR_W:0] diff;
	logic            prep_empty;
	len_t            prep_req;
	logic            prep_direct;

	// Segment datapath.
	chain_t   chain [WIN_COUNT+1];
	probe_t   probe;
	upd_t     upd;
	logic     seg_hit;
	win_idx_t seg_win;
	rank_t    seg_rank;
	fill_t    seg_fill;
	fill_t    seg_room;
	fill_t    seg_rem;
	fill_t    seg_copy;
	logic     seg_last;

	logic accept_in;
	logic load_single;
	logic load_seg;

	assign cfg_ready = 1'b1;
	assign inv       = cfg_valid && (cfg_index == REG_STORE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_size_q <= '0;
			read_ahead_q <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_STORE_SIZE: store_size_q <= cfg_data;
				REG_READ_AHEAD: read_ahead_q <= cfg_data[0];
				default:        read_ahead_q <= read_ahead_q;
			endcase
		end
	end

	// Clip to the end of the store. The subtract borrow means the position
	// lies beyond the store; a direct read covers anything wider than a window.
	assign diff        = {1'b0, store_size_q} - {1'b0, pos_q};
	assign prep_empty  = (len_q == '0) || diff[ADDR_W] || (diff[ADDR_W-1:0] == '0);
	assign prep_req    = (diff[ADDR_W-1:0] > addr_t'(len_q)) ? len_q : diff[LEN_W-1:0];
	assign prep_direct = !read_ahead_q || unc_q || (prep_req > len_t'(WIN_FULL));

	// Cell chain: lookup, first empty slot and least recently used slot.
	assign probe.base = pos_q[ADDR_W-1:WIN_SHIFT];
	assign probe.off  = pos_q[WIN_SHIFT-1:0];
	assign chain[0]   = '0;

	for (genvar i = 0; i < WIN_COUNT; i++) begin : g_cell
		rawc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (win_idx_t'(i)),
			.inv      (inv),
			.probe    (probe),
			.upd      (upd),
			.chain_in (chain[i]),
			.chain_out(chain[i+1])
		);
	end

	always_comb begin
		seg_hit = chain[WIN_COUNT].hit;
		if (seg_hit) begin
			seg_win  = chain[WIN_COUNT].hit_idx;
			seg_rank = chain[WIN_COUNT].hit_rank;
			seg_fill = chain[WIN_COUNT].hit_fill;
		end else begin
			if (chain[WIN_COUNT].free) begin
				seg_win  = chain[WIN_COUNT].free_idx;
				seg_rank = chain[WIN_COUNT].free_rank;
			end else begin
				seg_win  = chain[WIN_COUNT].lru_idx;
				seg_rank = chain[WIN_COUNT].lru_rank;
			end
			// The segment starts below the store's end, so a window sharing the
			// store's last window number is filled only up to that end.
			if (store_size_q[ADDR_W-1:WIN_SHIFT] > probe.base) begin
				seg_fill = WIN_FULL;
			end else begin
				seg_fill = {1'b0, store_size_q[WIN_SHIFT-1:0]};
			end
		end
		seg_room = seg_fill - {1'b0, probe.off};
		seg_rem  = req_q[FILL_W-1:0];
		seg_copy = (seg_room < seg_rem) ? seg_room : seg_rem;
		seg_last = (seg_room >= seg_rem) || !first_q;
	end

	assign upd.en   = load_seg;
	assign upd.load = !seg_hit;
	assign upd.win  = seg_win;
	assign upd.base = probe.base;
	assign upd.fill = seg_fill;
	assign upd.rank = seg_rank;

	// Control.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		accept_in   = 1'b0;
		load_single = 1'b0;
		load_seg    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				accept_in = in_valid;
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = (prep_empty || prep_direct) ? ST_SINGLE : ST_SEG;
			end
			ST_SINGLE: begin
				if (out_free) begin
					load_single = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_SEG: begin
				if (out_free) begin
					load_seg = 1'b1;
					if (seg_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			pos_q <= position;
			len_q <= length;
			unc_q <= uncached;
		end else if (load_seg) begin
			pos_q <= {probe.base + base_t'(1), off_t'(0)};
		end
		if (state_q == ST_PREP) begin
			empty_q  <= prep_empty;
			req_q    <= prep_req;
			first_q  <= 1'b1;
		end else if (load_seg) begin
			req_q   <= req_q - len_t'(seg_copy);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || load_seg) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			out_action_q <= empty_q ? ACT_NONE : ACT_DIRECT;
			out_win_q    <= '0;
			out_fetch_q  <= empty_q ? addr_t'(0) : pos_q;
			out_fill_q   <= '0;
			out_off_q    <= '0;
			out_seg_q    <= empty_q ? len_t'(0) : req_q;
			out_last_q   <= 1'b1;
		end else if (load_seg) begin
			out_action_q <= seg_hit ? ACT_HIT : ACT_FILL;
			out_win_q    <= seg_win;
			out_fetch_q  <= seg_hit ? addr_t'(0) : {probe.base, off_t'(0)};
			out_fill_q   <= seg_hit ? fill_t'(0) : seg_fill;
			out_off_q    <= probe.off;
			out_seg_q    <= len_t'(seg_copy);
			out_last_q   <= seg_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_action_q;
	assign window_index  = out_win_q;
	assign fetch_address = out_fetch_q;
	assign fill_bytes    = out_fill_q;
	assign window_offset = out_off_q;
	assign segment_bytes = out_seg_q;
	assign last          = out_last_q;

endmodule

@@ hw/rtl/rawc_checker.sv @@
// ----------------------------------------------------------------------------
// rawc_checker
// Port-level checks on the results of the read-ahead window cache.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rawc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            action,
	input logic [1:0]            window_index,
	input rawc_pkg::addr_t       fetch_address,
	input rawc_pkg::fill_t       fill_bytes,
	input rawc_pkg::off_t        window_offset,
	input rawc_pkg::len_t        segment_bytes,
	input logic                  last
);
	import rawc_pkg::*;

	`RAWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(segment_bytes) && $stable(action), "result changed while stalled")
	`RAWC_ASSERT_SAME(a_none_zero, out_valid && (action == ACT_NONE), last && (window_index == 2'd0) && (fetch_address == '0) && (fill_bytes == '0) && (segment_bytes == '0), "empty result carries data")
	`RAWC_ASSERT_SAME(a_direct_shape, out_valid && (action == ACT_DIRECT), last && (fill_bytes == '0) && (window_offset == '0) && (segment_bytes != '0), "bad direct read result")
	`RAWC_ASSERT_SAME(a_hit_shape, out_valid && (action == ACT_HIT), (fetch_address == '0) && (fill_bytes == '0) && (segment_bytes != '0), "bad window hit result")
	`RAWC_ASSERT_SAME(a_fill_shape, out_valid && (action == ACT_FILL), (fetch_address[WIN_SHIFT-1:0] == '0) && ({1'b0, window_offset} < fill_bytes), "bad window fill result")

endmodule

bind read_ahead_window_cache_core rawc_checker u_rawc_checker (.*);

@@ bench/rawc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawc_scoreboard
// Watches the register, request and segment channels of the read-ahead window
// cache, keeps its own copy of the windows and LRU ranks, and compares every
// segment the block returns against the segment this copy predicts.
// ----------------------------------------------------------------------------
module rawc_scoreboard
	import rawc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  logic     cfg_index,
	input  addr_t    cfg_data,
	input  logic     in_valid,
	input  logic     in_ready,
	input  addr_t    position,
	input  len_t     length,
	input  logic     uncached,
	input  logic     out_valid,
	input  logic     out_ready,
	input  logic [1:0] action,
	input  logic [1:0] window_index,
	input  addr_t    fetch_address,
	input  fill_t    fill_bytes,
	input  off_t     window_offset,
	input  len_t     segment_bytes,
	input  logic     last,
	output int       fail_count,
	output int       segments_owed
);

	localparam longint unsigned WIN_BYTES = 64'd1 << WIN_SHIFT;

	typedef struct packed {
		action_t    act;
		logic [1:0] win;
		addr_t      fetch;
		fill_t      fill;
		off_t       off;
		len_t       bytes;
		logic       last;
	} segment_t;

	segment_t owed[$];

	logic  win_valid [WIN_COUNT];
	base_t win_base  [WIN_COUNT];
	fill_t win_fill  [WIN_COUNT];
	rank_t win_rank  [WIN_COUNT];

	longint unsigned store_bytes;
	logic            read_ahead;
	int              seen_count;

	task automatic log_mismatch(string field, longint unsigned got_v, longint unsigned want_v);
		$display("[%0t] segment %0d: %s is %0h, expected %0h",
			$time, seen_count, field, got_v, want_v);
		fail_count++;
	endtask

	function automatic int find_window(longint unsigned p);
		longint unsigned start;
		for (int i = 0; i < WIN_COUNT; i++) begin
			start = longint'(win_base[i]) << WIN_SHIFT;
			if (win_valid[i] && p >= start && p - start < win_fill[i])
				return i;
		end
		return -1;
	endfunction

	// An empty window wins, lowest index first; otherwise the highest rank.
	function automatic int choose_victim();
		int oldest;
		oldest = 0;
		for (int i = 0; i < WIN_COUNT; i++)
			if (!win_valid[i])
				return i;
		for (int i = 1; i < WIN_COUNT; i++)
			if (win_rank[i] > win_rank[oldest])
				oldest = i;
		return oldest;
	endfunction

	function automatic void promote(int w);
		rank_t r;
		r = win_rank[w];
		for (int j = 0; j < WIN_COUNT; j++)
			if (win_rank[j] < r)
				win_rank[j]++;
		win_rank[w] = '0;
	endfunction

	function automatic void predict_request(addr_t pos, len_t len, logic unc);
		longint unsigned want, done, p, start, fill, off, copy;
		int w;
		int n;
		segment_t s;
		done = 0;
		n = 0;
		if (len == 0 || longint'(pos) >= store_bytes) begin
			owed.push_back('{ACT_NONE, 2'd0, '0, '0, '0, '0, 1'b1});
			return;
		end
		want = store_bytes - pos;
		if (want > len)
			want = len;
		if (!read_ahead || unc || want > WIN_BYTES) begin
			owed.push_back('{ACT_DIRECT, 2'd0, pos, '0, '0, len_t'(want), 1'b1});
			return;
		end
		while (n < 2 && done < want) begin
			p = longint'(pos) + done;
			w = find_window(p);
			if (w >= 0) begin
				start = longint'(win_base[w]) << WIN_SHIFT;
				fill = win_fill[w];
				s.act = ACT_HIT;
				s.fetch = '0;
				s.fill = '0;
			end else begin
				w = choose_victim();
				start = (p >> WIN_SHIFT) << WIN_SHIFT;
				fill = store_bytes - start;
				if (fill > WIN_BYTES)
					fill = WIN_BYTES;
				win_valid[w] = 1'b1;
				win_base[w] = base_t'(p >> WIN_SHIFT);
				win_fill[w] = fill_t'(fill);
				s.act = ACT_FILL;
				s.fetch = addr_t'(start);
				s.fill = fill_t'(fill);
			end
			promote(w);
			off = p - start;
			copy = fill - off;
			if (copy > want - done)
				copy = want - done;
			s.win = w[1:0];
			s.off = off_t'(off);
			s.bytes = len_t'(copy);
			s.last = 1'b0;
			owed.push_back(s);
			n++;
			done += copy;
		end
		owed[owed.size() - 1].last = 1'b1;
	endfunction

	function automatic void write_register(logic idx, addr_t data);
		case (reg_idx_t'(idx))
			REG_STORE_SIZE: begin
				// A new size drops every window; ranks stay as they were.
				store_bytes = data;
				for (int i = 0; i < WIN_COUNT; i++)
					win_valid[i] = 1'b0;
			end
			REG_READ_AHEAD: begin
				read_ahead = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_segment();
		segment_t want;
		seen_count++;
		if (owed.size() == 0) begin
			log_mismatch("unrequested segment, action", action, 0);
			return;
		end
		want = owed.pop_front();
		if (action != want.act)
			log_mismatch("action", action, want.act);
		if (window_index != want.win)
			log_mismatch("window_index", window_index, want.win);
		if (fetch_address != want.fetch)
			log_mismatch("fetch_address", fetch_address, want.fetch);
		if (fill_bytes != want.fill)
			log_mismatch("fill_bytes", fill_bytes, want.fill);
		if (window_offset != want.off)
			log_mismatch("window_offset", window_offset, want.off);
		if (segment_bytes != want.bytes)
			log_mismatch("segment_bytes", segment_bytes, want.bytes);
		if (last != want.last)
			log_mismatch("last", last, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_COUNT; i++) begin
				win_valid[i] = 1'b0;
				win_base[i] = '0;
				win_fill[i] = '0;
				win_rank[i] = rank_t'(i);
			end
			store_bytes = 0;
			read_ahead = 1'b0;
			seen_count = 0;
			fail_count = 0;
			owed.delete();
			segments_owed <= 0;
		end else begin
			// Segments leaving now belong to requests taken on earlier edges.
			if (out_valid && out_ready)
				check_segment();
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				predict_request(position, length, uncached);
			segments_owed <= owed.size();
		end
	end

endmodule

@@ bench/tb_read_ahead_window_cache_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_read_ahead_window_cache_core
// Drives register writes and read requests into the read-ahead window cache
// with random gaps and output stalls; a checker beside the block predicts each
// segment and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_read_ahead_window_cache_core;
	import rawc_pkg::*;

	localparam longint unsigned WIN_BYTES = 64'd1 << WIN_SHIFT;
	localparam longint unsigned ADDR_MAX = 40'hFF_FFFF_FFFF;
	// Well above the slowest legal run of about 550 requests.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 66;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	addr_t      cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	addr_t      position = '0;
	len_t       length = '0;
	logic       uncached = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] action;
	logic [1:0] window_index;
	addr_t      fetch_address;
	fill_t      fill_bytes;
	off_t       window_offset;
	len_t       segment_bytes;
	logic       last;

	int fail_count;
	int segments_owed;

	// Percentage of cycles in which the sender idles and the receiver stalls.
	int idle_pct = 36;
	int cycle_count = 0;

	// Size last written to the block, used to aim requests at its windows.
	longint unsigned store_now = 0;

	read_ahead_window_cache_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.position      (position),
		.length        (length),
		.uncached      (uncached),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.window_index  (window_index),
		.fetch_address (fetch_address),
		.fill_bytes    (fill_bytes),
		.window_offset (window_offset),
		.segment_bytes (segment_bytes),
		.last          (last)
	);

	rawc_scoreboard u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.position      (position),
		.length        (length),
		.uncached      (uncached),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.window_index  (window_index),
		.fetch_address (fetch_address),
		.fill_bytes    (fill_bytes),
		.window_offset (window_offset),
		.segment_bytes (segment_bytes),
		.last          (last),
		.fail_count    (fail_count),
		.segments_owed (segments_owed)
	);

	always #4 clk = ~clk;

	// The receiver stalls at random, independent of out_valid, which the
	// handshake allows. With idle_pct at zero it takes every segment at once.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offers one request and returns on the edge of its transfer. in_valid is
	// left high; the next call either lowers it for a gap or replaces the
	// payload, so it never sees two assignments in one step.
	task automatic send_request(addr_t pos, len_t len, logic unc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		position <= pos;
		length <= len;
		uncached <= unc;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Holds the sender back until every predicted segment has come out. Every
	// request yields at least one segment, so an empty count means the block
	// is idle and may take a register write.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (segments_owed != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, addr_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_STORE_SIZE)
			store_now = data;
	endtask

	function automatic longint unsigned random_addr();
		return {$urandom(), $urandom()} & ADDR_MAX;
	endfunction

	// Picks an aligned base for a run of six windows. With only four windows
	// in the block, requests around it mix hits, fills and evictions.
	function automatic longint unsigned pick_hot_base(longint unsigned store);
		if (store <= 6 * WIN_BYTES)
			return 0;
		if ($urandom_range(2) == 0)
			return ((store - 5 * WIN_BYTES) >> WIN_SHIFT) << WIN_SHIFT;
		return ((random_addr() % (store - 6 * WIN_BYTES)) >> WIN_SHIFT) << WIN_SHIFT;
	endfunction

	// Most requests are cacheable reads around the hot base with lengths up
	// to one window, so segments cross window edges and the store's end. The
	// rest are empty requests, over-long direct reads and raw noise.
	task automatic random_request(longint unsigned hot);
		longint unsigned p;
		longint unsigned len;
		logic unc;
		int pick;
		pick = $urandom_range(99);
		unc = ($urandom_range(19) == 0);
		p = hot + $urandom_range(0, 6 * WIN_BYTES - 1);
		if (pick < 70) begin
			case ($urandom_range(3))
				0: len = $urandom_range(1, 256);
				1: len = $urandom_range(1, WIN_BYTES);
				2: len = WIN_BYTES - $urandom_range(0, 1);
				default: len = $urandom_range(WIN_BYTES - 4096, WIN_BYTES);
			endcase
		end else if (pick < 80) begin
			if ($urandom_range(1) == 0) begin
				len = 0;
			end else begin
				p = store_now + $urandom_range(0, 3000);
				len = $urandom_range(1, WIN_BYTES);
			end
		end else if (pick < 88) begin
			len = ($urandom_range(1) == 0) ? $urandom_range(WIN_BYTES + 1, 4 * WIN_BYTES)
				: $urandom();
		end else begin
			p = random_addr();
			len = $urandom();
			unc = 1'($urandom_range(1));
		end
		send_request(addr_t'(p), len_t'(len), unc);
	endtask

	initial begin
		longint unsigned hot;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the store is empty: every request reads nothing.
		send_request(40'd0, 32'd0, 1'b0);
		send_request(40'd5, 32'd100, 1'b0);
		drain();

		// A store of 300000 bytes ends part way into its fifth window.
		write_reg(REG_STORE_SIZE, 40'd300000);
		write_reg(REG_READ_AHEAD, 40'd1);
		send_request(40'd0, 32'd1, 1'b0);            // first fill of an empty window
		send_request(40'd100, 32'd200, 1'b0);        // hit in that window
		send_request(40'd65530, 32'd100, 1'b0);      // hit, then fill across the edge
		send_request(40'd131077, 32'd65536, 1'b0);   // exactly one window, two fills
		send_request(40'd270000, 32'd65536, 1'b0);   // clipped, short last window, LRU victim
		send_request(40'd299999, 32'd10, 1'b0);      // last byte of the store
		send_request(40'd300000, 32'd5, 1'b0);       // position at the store's end
		send_request(40'd1000, 32'd65537, 1'b0);     // one byte over a window: direct
		send_request(40'd1000, 32'd50, 1'b1);        // uncached hint: direct
		send_request(40'd0, 32'hFFFF_FFFF, 1'b0);    // longest length, clipped, direct
		drain();

		write_reg(REG_READ_AHEAD, 40'd0);
		send_request(40'd1000, 32'd50, 1'b0);        // read-ahead off: direct
		drain();

		// The largest store puts every position bit in play; its last window
		// holds one byte less than a full window.
		write_reg(REG_STORE_SIZE, addr_t'(ADDR_MAX));
		write_reg(REG_READ_AHEAD, 40'd1);
		send_request(40'hFF_FFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
		send_request(40'hFF_FFFF_0000, 32'd65535, 1'b0);
		send_request(40'hFF_FFFE_FFFF, 32'd2, 1'b0);
		send_request(40'hFF_FFFF_FFFE, 32'd1, 1'b1);
		drain();

		// Random phases, each under its own register setting. Phase 2 keeps
		// the windows of phase 1 alive, phase 5 runs with read-ahead off, and
		// phase 3 runs with no random gaps and no stalls.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph != 2) begin
				case (ph % 4)
					0: write_reg(REG_STORE_SIZE, addr_t'(ADDR_MAX));
					1: write_reg(REG_STORE_SIZE, addr_t'($urandom_range(1, 8) * WIN_BYTES));
					2: write_reg(REG_STORE_SIZE, addr_t'($urandom_range(1, 600000)));
					default: write_reg(REG_STORE_SIZE, addr_t'(random_addr()));
				endcase
			end
			write_reg(REG_READ_AHEAD, (ph == 5) ? 40'd0 : 40'd1);
			idle_pct = (ph == 3) ? 0 : 36;
			hot = pick_hot_base(store_now);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Mid-phase the sender waits for the block to empty out.
				if (k == PHASE_ITEMS / 2)
					drain();
				if (k % 16 == 15)
					hot = pick_hot_base(store_now);
				random_request(hot);
			end
		end

		idle_pct = 36;
		drain();
		// A few more cycles catch any segment the block sends unasked.
		repeat (16) @(posedge clk);
		if (fail_count == 0 && segments_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ read_ahead_window_cache_core.f @@
+incdir+hw/rtl
hw/rtl/rawc_pkg.sv
hw/rtl/rawc_cell.sv
hw/rtl/read_ahead_window_cache_core.sv
hw/rtl/rawc_checker.sv
bench/rawc_checker.sv
bench/tb_read_ahead_window_cache_core.sv
